>>> hdl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg: shared definitions for the line-follow PID drive
// Register indexes, reset values, fixed-point constants, sequencer states
// and the steering table of the wheel drive.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    // Field widths
    localparam int DistW   = 11;
    localparam int HitsW   = 5;
    localparam int SpeedW  = 7;
    localparam int GainW   = 16;
    localparam int CmpW    = 10;
    localparam int FracW   = 10;
    localparam int ErrW    = 12;
    localparam int ISumW   = 20;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 16;

    // Shared multiplier operand and product widths
    localparam int MulAW = 19;
    localparam int MulBW = 21;
    localparam int ProdW = 40;

    // Register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_SETPOINT  = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_CRUISE    = 3'd2,
        REG_GAIN_P    = 3'd3,
        REG_GAIN_I    = 3'd4,
        REG_GAIN_D    = 3'd5
    } t_reg_idx;

    // Register reset values
    localparam logic [DistW-1:0]  RstSetpoint  = 11'd10;
    localparam logic [DistW-1:0]  RstThreshold = 11'd15;
    localparam logic [SpeedW-1:0] RstCruise    = 7'd60;
    localparam logic [GainW-1:0]  RstGainP     = 16'd2867;
    localparam logic [GainW-1:0]  RstGainI     = 16'd614;
    localparam logic [GainW-1:0]  RstGainD     = 16'd410;

    // PID output limit in Q12 and integral limit
    localparam logic signed [ProdW-1:0] OutLimitQ12 = 40'sd819200;
    localparam logic [7:0]              OutMax      = 8'd200;
    localparam logic signed [MulBW-1:0] ISumMax     = 21'sd524287;
    localparam logic signed [MulBW-1:0] ISumMin     = -21'sd524287;

    // Reciprocals for the constant divisions (multiply, then shift)
    localparam logic signed [MulAW-1:0] RecipFive     = 19'sd205;    // >> 10
    localparam logic signed [MulAW-1:0] RecipThousand = 19'sd134218; // >> 27
    localparam logic signed [MulAW-1:0] RecipTen      = 19'sd3277;   // >> 15

    // Wheel mapping slopes (per ten) and pulse offsets (us)
    localparam logic signed [MulAW-1:0] SlopeRight = 19'sd19;
    localparam logic signed [MulAW-1:0] SlopeLeft  = 19'sd21;
    localparam logic [10:0]             BaseRight  = 11'd1470;
    localparam logic [10:0]             BaseLeft   = 11'd1520;
    localparam logic [CmpW-1:0]         StopCmp    = 10'd750;

    // Sequencer states, one-hot
    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_PREP  = 15'b000000000000010,
        ST_MUL_P = 15'b000000000000100,
        ST_MUL_I = 15'b000000000001000,
        ST_MUL_D = 15'b000000000010000,
        ST_SUM   = 15'b000000000100000,
        ST_CLAMP = 15'b000000001000000,
        ST_SPEED = 15'b000000010000000,
        ST_SPDQ  = 15'b000000100000000,
        ST_W_FR  = 15'b000001000000000,
        ST_W_QT  = 15'b000010000000000,
        ST_W_SL  = 15'b000100000000000,
        ST_W_DV  = 15'b001000000000000,
        ST_W_WR  = 15'b010000000000000,
        ST_FIN   = 15'b100000000000000
    } t_state;

    // Steering table: wheel fraction in thousandths, first matching case wins.
    // The cases on bits 4:3 are checked first, then centre bit 2, then bits 1:0.
    function automatic logic [FracW-1:0] steer_frac(input logic [HitsW-1:0] hits,
                                                    input logic left_side);
        logic [FracW-1:0] frac;
        frac = 10'd0;
        if (hits[3] || hits[4]) begin
            if (!left_side) begin
                frac = 10'd17;
            end else if (hits[3] && hits[4]) begin
                frac = 10'd900;
            end else if (hits[4]) begin
                frac = 10'd850;
            end else begin
                frac = 10'd450;
            end
        end else if (hits[2]) begin
            frac = left_side ? 10'd583 : 10'd833;
        end else if (hits[0] || hits[1]) begin
            if (left_side) begin
                frac = 10'd0;
            end else if (hits[0] && hits[1]) begin
                frac = 10'd750;
            end else if (hits[0]) begin
                frac = 10'd1000;
            end else begin
                frac = 10'd583;
            end
        end
        return frac;
    endfunction

endpackage

>>> hdl/line_follow_pid_drive.sv
// ----------------------------------------------------------------------------
// line_follow_pid_drive: obstacle-aware line-following wheel drive
// PID speed control on obstacle distance and line-sensor steering, giving
// two servo compare values per item.
// ----------------------------------------------------------------------------
// One input transfer yields one result transfer. Every multiplication goes
// through a single shared 19 x 21 bit signed multiplier with a registered
// product, stepped by a small sequencer, so the input is not ready while an
// item is in work. An item within the PID threshold runs the PID terms, clamp,
// speed scaling and two wheel passes (fraction, quotient, slope and divide
// steps on the multiplier, then a write); a far item goes straight to the
// wheel passes, and an item with no line seen skips them. A finished result
// waits in the output register, and the next item may be taken meanwhile.
// Registers are written over the configuration channel, which is always ready.
// ----------------------------------------------------------------------------
module line_follow_pid_drive (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [10:0] distance_cm, [15:11] line_hits
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [9:0] right_compare, [19:10] left_compare,
                                       // [23:20] zero
    output logic [1:0]  m_axis_tuser   // [0] pid_active, [1] stopped
);

    localparam int DistW  = lfpd_pkg::DistW;
    localparam int HitsW  = lfpd_pkg::HitsW;
    localparam int SpeedW = lfpd_pkg::SpeedW;
    localparam int GainW  = lfpd_pkg::GainW;
    localparam int CmpW   = lfpd_pkg::CmpW;
    localparam int ErrW   = lfpd_pkg::ErrW;
    localparam int ISumW  = lfpd_pkg::ISumW;
    localparam int MulAW  = lfpd_pkg::MulAW;
    localparam int MulBW  = lfpd_pkg::MulBW;
    localparam int ProdW  = lfpd_pkg::ProdW;

    // Configuration registers
    logic [DistW-1:0]  r_setpoint;
    logic [DistW-1:0]  r_threshold;
    logic [SpeedW-1:0] r_cruise;
    logic [GainW-1:0]  r_gain_p;
    logic [GainW-1:0]  r_gain_i;
    logic [GainW-1:0]  r_gain_d;

    // Controller state
    logic signed [ErrW-1:0]  r_last;
    logic signed [ISumW-1:0] r_isum;
    logic [CmpW-1:0]         r_held_right;
    logic [CmpW-1:0]         r_held_left;

    // Item work registers
    lfpd_pkg::t_state        r_state;
    lfpd_pkg::t_state        n_state;
    logic [DistW-1:0]        r_dist;
    logic [HitsW-1:0]        r_hits;
    logic                    r_active;
    logic                    r_left_side;
    logic signed [ErrW-1:0]  r_err;
    logic signed [ErrW:0]    r_diff;
    logic signed [ProdW-1:0] r_prod;
    logic signed [ProdW-1:0] r_acc;
    logic [7:0]              r_pid_out;
    logic [SpeedW-1:0]       r_speed;

    // Output register
    logic            r_mvalid;
    logic [CmpW-1:0] r_out_right;
    logic [CmpW-1:0] r_out_left;
    logic            r_out_active;
    logic            r_out_stopped;

    // Shared multiplier
    logic signed [MulAW-1:0] w_mul_a;
    logic signed [MulBW-1:0] w_mul_b;
    logic signed [ProdW-1:0] w_prod;

    // Combinational helpers
    logic                    w_in_xfer;
    logic signed [ErrW-1:0]  w_err;
    logic signed [ISumW-1:0] w_isum_base;
    logic signed [MulBW-1:0] w_isum_sum;
    logic signed [ISumW-1:0] w_isum_sat;
    logic                    w_match;
    logic                    w_stop;
    logic [8:0]              w_wheel_y;
    logic [10:0]             w_right_us;
    logic [10:0]             w_left_us;
    logic                    w_out_free;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == lfpd_pkg::ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_mvalid || m_axis_tready;

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {4'd0, r_out_left, r_out_right};
    assign m_axis_tuser  = {r_out_stopped, r_out_active};

    // Error, integral clear and saturation for the PID step
    always_comb begin
        w_err = $signed({1'b0, r_dist}) - $signed({1'b0, r_setpoint});
        if ((w_err == '0) || (w_err > $signed({1'b0, r_setpoint}))) begin
            w_isum_base = '0;
        end else begin
            w_isum_base = r_isum;
        end
        w_isum_sum = MulBW'(w_isum_base) + MulBW'(w_err);
        if (w_isum_sum > lfpd_pkg::ISumMax) begin
            w_isum_sat = ISumW'(lfpd_pkg::ISumMax);
        end else if (w_isum_sum < lfpd_pkg::ISumMin) begin
            w_isum_sat = ISumW'(lfpd_pkg::ISumMin);
        end else begin
            w_isum_sat = ISumW'(w_isum_sum);
        end
    end

    // Any sensor case matches when at least one line bit is set.
    assign w_match = (r_hits != '0);
    assign w_stop  = r_active && (r_dist < r_setpoint);

    // Wheel pulse from the scaled offset of the current pass
    assign w_wheel_y  = r_prod[23:15];
    assign w_right_us = lfpd_pkg::BaseRight - {2'b00, w_wheel_y};
    assign w_left_us  = lfpd_pkg::BaseLeft + {2'b00, w_wheel_y};

    // Operand selection for the shared multiplier
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            lfpd_pkg::ST_MUL_P: begin
                w_mul_a = $signed({3'b000, r_gain_p});
                w_mul_b = MulBW'(r_err);
            end
            lfpd_pkg::ST_MUL_I: begin
                w_mul_a = $signed({3'b000, r_gain_i});
                w_mul_b = MulBW'(r_isum);
            end
            lfpd_pkg::ST_MUL_D: begin
                w_mul_a = $signed({3'b000, r_gain_d});
                w_mul_b = MulBW'(r_diff);
            end
            lfpd_pkg::ST_SPEED: begin
                w_mul_a = lfpd_pkg::RecipFive;
                w_mul_b = $signed({12'd0, r_pid_out, 1'b0});
            end
            lfpd_pkg::ST_W_FR: begin
                w_mul_a = $signed({12'd0, r_speed});
                w_mul_b = $signed({11'd0, lfpd_pkg::steer_frac(r_hits, r_left_side)});
            end
            lfpd_pkg::ST_W_QT: begin
                w_mul_a = lfpd_pkg::RecipThousand;
                w_mul_b = $signed({4'd0, r_prod[16:0]});
            end
            lfpd_pkg::ST_W_SL: begin
                w_mul_a = r_left_side ? lfpd_pkg::SlopeLeft : lfpd_pkg::SlopeRight;
                w_mul_b = $signed({14'd0, r_prod[33:27]});
            end
            lfpd_pkg::ST_W_DV: begin
                w_mul_a = lfpd_pkg::RecipTen;
                w_mul_b = $signed({9'd0, r_prod[11:0]});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Next-state logic of the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfpd_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    if (s_axis_tdata[10:0] <= r_threshold) begin
                        n_state = lfpd_pkg::ST_PREP;
                    end else if (s_axis_tdata[15:11] != '0) begin
                        n_state = lfpd_pkg::ST_W_FR;
                    end else begin
                        n_state = lfpd_pkg::ST_FIN;
                    end
                end
            end
            lfpd_pkg::ST_PREP:  n_state = lfpd_pkg::ST_MUL_P;
            lfpd_pkg::ST_MUL_P: n_state = lfpd_pkg::ST_MUL_I;
            lfpd_pkg::ST_MUL_I: n_state = lfpd_pkg::ST_MUL_D;
            lfpd_pkg::ST_MUL_D: n_state = lfpd_pkg::ST_SUM;
            lfpd_pkg::ST_SUM:   n_state = lfpd_pkg::ST_CLAMP;
            lfpd_pkg::ST_CLAMP: n_state = lfpd_pkg::ST_SPEED;
            lfpd_pkg::ST_SPEED: n_state = lfpd_pkg::ST_SPDQ;
            lfpd_pkg::ST_SPDQ:  n_state = w_match ? lfpd_pkg::ST_W_FR : lfpd_pkg::ST_FIN;
            lfpd_pkg::ST_W_FR:  n_state = lfpd_pkg::ST_W_QT;
            lfpd_pkg::ST_W_QT:  n_state = lfpd_pkg::ST_W_SL;
            lfpd_pkg::ST_W_SL:  n_state = lfpd_pkg::ST_W_DV;
            lfpd_pkg::ST_W_DV:  n_state = lfpd_pkg::ST_W_WR;
            lfpd_pkg::ST_W_WR:  n_state = r_left_side ? lfpd_pkg::ST_FIN : lfpd_pkg::ST_W_FR;
            lfpd_pkg::ST_FIN: begin
                if (w_out_free) begin
                    n_state = lfpd_pkg::ST_IDLE;
                end
            end
            default: n_state = lfpd_pkg::ST_IDLE;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= lfpd_pkg::RstSetpoint;
            r_threshold <= lfpd_pkg::RstThreshold;
            r_cruise    <= lfpd_pkg::RstCruise;
            r_gain_p    <= lfpd_pkg::RstGainP;
            r_gain_i    <= lfpd_pkg::RstGainI;
            r_gain_d    <= lfpd_pkg::RstGainD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lfpd_pkg::REG_SETPOINT:  r_setpoint  <= i_cfg_data[DistW-1:0];
                lfpd_pkg::REG_THRESHOLD: r_threshold <= i_cfg_data[DistW-1:0];
                lfpd_pkg::REG_CRUISE:    r_cruise    <= i_cfg_data[SpeedW-1:0];
                lfpd_pkg::REG_GAIN_P:    r_gain_p    <= i_cfg_data;
                lfpd_pkg::REG_GAIN_I:    r_gain_i    <= i_cfg_data;
                lfpd_pkg::REG_GAIN_D:    r_gain_d    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer, controller state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lfpd_pkg::ST_IDLE;
            r_last        <= '0;
            r_isum        <= '0;
            r_held_right  <= '0;
            r_held_left   <= '0;
            r_mvalid      <= 1'b0;
        end else begin
            r_state <= n_state;

            // Result transfer frees the output register.
            if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end

            // PID error terms and integral update
            if (r_state == lfpd_pkg::ST_PREP) begin
                r_last <= w_err;
                r_isum <= w_isum_sat;
            end

            // Wheel pass writes the held compare value of its side.
            if (r_state == lfpd_pkg::ST_W_WR) begin
                if (r_left_side) begin
                    r_held_left <= w_left_us[CmpW:1];
                end else begin
                    r_held_right <= w_right_us[CmpW:1];
                end
            end

            // Finish: stop override, then load the output register.
            if ((r_state == lfpd_pkg::ST_FIN) && w_out_free) begin
                r_mvalid <= 1'b1;
                if (w_stop) begin
                    r_held_right <= lfpd_pkg::StopCmp;
                    r_held_left  <= lfpd_pkg::StopCmp;
                end
            end
        end
    end

    // Item datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;

        unique case (r_state)
            lfpd_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    r_dist      <= s_axis_tdata[10:0];
                    r_hits      <= s_axis_tdata[15:11];
                    r_active    <= (s_axis_tdata[10:0] <= r_threshold);
                    r_speed     <= r_cruise;
                    r_left_side <= 1'b0;
                end
            end
            lfpd_pkg::ST_PREP: begin
                r_err  <= w_err;
                r_diff <= $signed({w_err[ErrW-1], w_err}) - $signed({r_last[ErrW-1], r_last});
            end
            lfpd_pkg::ST_MUL_I: begin
                r_acc <= r_prod;
            end
            lfpd_pkg::ST_MUL_D, lfpd_pkg::ST_SUM: begin
                r_acc <= r_acc + r_prod;
            end
            lfpd_pkg::ST_CLAMP: begin
                if (r_acc >= lfpd_pkg::OutLimitQ12) begin
                    r_pid_out <= lfpd_pkg::OutMax;
                end else if (r_acc < 0) begin
                    r_pid_out <= '0;
                end else begin
                    r_pid_out <= r_acc[19:12];
                end
            end
            lfpd_pkg::ST_SPDQ: begin
                r_speed <= r_prod[16:10];
            end
            lfpd_pkg::ST_W_WR: begin
                r_left_side <= 1'b1;
            end
            lfpd_pkg::ST_FIN: begin
                if (w_out_free) begin
                    r_out_right   <= w_stop ? lfpd_pkg::StopCmp : r_held_right;
                    r_out_left    <= w_stop ? lfpd_pkg::StopCmp : r_held_left;
                    r_out_active  <= r_active;
                    r_out_stopped <= w_stop;
                end
            end
            default: ;
        endcase
    end

endmodule
